@@ src/sro_pkg.sv @@
`timescale 1ns / 1ps

package sro_pkg;

	// Default table depth.
	localparam int MAX_RANGES_DEF = 64;

	// Widths of the item fields.
	localparam int ADDR_W  = 64;
	localparam int FUNC_W  = 2;
	localparam int COUNT_W = 7;

	// One table entry: {signed mark, end, start}.
	localparam int ENTRY_W = 2 * ADDR_W + 1;

	// Address bits of a PSW that are compared against range starts.
	localparam logic [ADDR_W-1:0] PSW_ADDR_MASK = 64'h0000_0000_3FFF_FFFF;

	// Operation codes carried on the input tuser.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_CHECK = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	// Control from the sequencer to the compare stage.
	typedef struct packed {
		logic clr;
		logic vld;
	} match_ctl_t;

	// Accumulated hits of a table walk.
	typedef struct packed {
		logic ovl;
		logic lpsw;
		logic apsw;
	} hits_t;

endpackage

@@ src/sro_ram.sv @@
`timescale 1ns / 1ps

module sro_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/sro_match.sv @@
`timescale 1ns / 1ps

module sro_match (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sro_pkg::match_ctl_t               ctl,
	input  logic [sro_pkg::ENTRY_W-1:0]       entry,
	input  logic [sro_pkg::ADDR_W-1:0]        range_lo,
	input  logic [sro_pkg::ADDR_W-1:0]        range_hi,
	input  logic [sro_pkg::ADDR_W-1:0]        boot_psw,
	input  logic [sro_pkg::ADDR_W-1:0]        attr_psw,
	output sro_pkg::hits_t                    hits
);
	import sro_pkg::*;

	logic [ADDR_W-1:0] ent_start;
	logic [ADDR_W-1:0] ent_end;
	logic              ent_sgn;
	logic [ADDR_W-1:0] lpsw_addr;
	logic [ADDR_W-1:0] apsw_addr;
	hits_t             cur;
	hits_t             hits_q;

	// Split the entry that the memory returned this cycle.
	assign ent_start = entry[ADDR_W-1:0];
	assign ent_end   = entry[2*ADDR_W-1:ADDR_W];
	assign ent_sgn   = entry[ENTRY_W-1];
	assign lpsw_addr = boot_psw & PSW_ADDR_MASK;
	assign apsw_addr = attr_psw & PSW_ADDR_MASK;

	// Compare one signed entry against the item operands.
	always_comb begin
		cur.ovl  = ent_sgn && (ent_start <= range_hi) && (range_lo <= ent_end);
		cur.lpsw = ent_sgn && (ent_start == lpsw_addr);
		cur.apsw = ent_sgn && (ent_start == apsw_addr);
	end

	// Sticky hits over the walk, cleared when an item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
		end else if (ctl.clr) begin
			hits_q <= '0;
		end else if (ctl.vld) begin
			hits_q <= hits_q | cur;
		end
	end

	assign hits = hits_q;

endmodule

@@ src/signed_range_overlap_table.sv @@
`timescale 1ns / 1ps
// Table of loaded address ranges with a signed mark, plus overlap and PSW checks.
// Input channel s_*: one item per operation, the operation code on s_tuser
// (clear, add range, check PSW, no-op). Output channel m_*: one result item per
// input item, in order.
// A clear or no-op goes straight to the result state once it is taken. An add or
// check walks every stored entry through the table memory, one read per cycle,
// and then drains the last read into the compare stage before its result; on an
// empty table it goes straight to the result state too. The single read port of
// the table memory is why the walk reads one entry at a time. One item is worked
// on at a time, so the next item is taken only after the last one's result is
// posted; s_tready is high while the sequencer is idle. The result sits in an
// output register, so the next item is taken while a result still waits. If the
// receiver stalls, a finished item holds in the sequencer until the output
// register is free.
// Reset clears the stored count and the handshake state; the table memory is
// not cleared, since entries at or above the count are never read.
module signed_range_overlap_table #(
	parameter int MAX_RANGES = sro_pkg::MAX_RANGES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata from bit 0: range_lo[63:0], range_hi[127:64], signed_flag[128],
	// boot_psw[192:129], attr_psw[256:193], zero fill [263:257]
	input  logic [263:0] s_tdata,
	// s_tuser: func[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata from bit 0: overlap[0], table_full[1], psw_invalid[2],
	// psw_mismatch[3], entry_count[10:4], zero fill [15:11]
	output logic [15:0]  m_tdata
);
	import sro_pkg::*;

	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW = $clog2(MAX_RANGES + 1);

	state_t            state_q;
	state_t            state_nxt;
	logic [CW-1:0]     total_q;
	logic [CW-1:0]     total_nxt;
	logic [CW-1:0]     scan_cnt_q;
	logic [CW-1:0]     scan_cnt_nxt;
	logic              vld_s1;
	func_t             func_q;
	logic [ADDR_W-1:0] start_q;
	logic [ADDR_W-1:0] end_q;
	logic              sgn_q;
	logic [ADDR_W-1:0] lpsw_q;
	logic [ADDR_W-1:0] apsw_q;
	logic              accept;
	logic              out_free;
	logic              rd_en;
	logic              wr_en;
	logic [ENTRY_W-1:0] rd_entry;
	logic              is_full;
	logic              res_ovl;
	logic              res_full;
	logic              res_inval;
	logic              res_mism;
	logic [CW+6:0]     count_ext;
	logic              load_out;
	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;
	match_ctl_t        mctl;
	hits_t             hits;
	func_t             in_func;

	assign in_func  = func_t'(s_tuser);
	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign is_full  = (total_q == CW'(MAX_RANGES));

	// Capture the operands of a taken item.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= in_func;
			start_q <= s_tdata[63:0];
			end_q   <= s_tdata[127:64];
			sgn_q   <= s_tdata[128];
			lpsw_q  <= s_tdata[192:129];
			apsw_q  <= s_tdata[256:193];
		end
	end

	// Result flags from the finished walk.
	always_comb begin
		res_ovl   = (func_q == FUNC_ADD) && hits.ovl;
		res_full  = (func_q == FUNC_ADD) && is_full;
		res_inval = (func_q == FUNC_CHECK) && !(hits.lpsw && hits.apsw);
		res_mism  = (func_q == FUNC_CHECK) && (lpsw_q != apsw_q);
	end

	// Sequencer: walk the table for an add or check on a non-empty table, then write back and post the result.
	always_comb begin
		state_nxt    = state_q;
		scan_cnt_nxt = scan_cnt_q;
		total_nxt    = total_q;
		rd_en        = 1'b0;
		wr_en        = 1'b0;
		load_out     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				scan_cnt_nxt = '0;
				if (accept) begin
					if ((in_func == FUNC_ADD || in_func == FUNC_CHECK) &&
					    total_q != '0) begin
						state_nxt = ST_SCAN;
					end else begin
						state_nxt = ST_RESULT;
					end
				end
			end
			ST_SCAN: begin
				rd_en        = 1'b1;
				scan_cnt_nxt = scan_cnt_q + CW'(1);
				if (scan_cnt_nxt == total_q) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
					case (func_q)
						FUNC_CLEAR: total_nxt = '0;
						FUNC_ADD: begin
							if (!hits.ovl && !is_full) begin
								wr_en     = 1'b1;
								total_nxt = total_q + CW'(1);
							end
						end
						default: total_nxt = total_q;
					endcase
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			scan_cnt_q <= '0;
			vld_s1     <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			total_q    <= total_nxt;
			scan_cnt_q <= scan_cnt_nxt;
			vld_s1     <= rd_en;
		end
	end

	// Table memory; reads and the write never overlap since one item runs at a time.
	sro_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_RANGES),
		.ADDR_W(AW)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (total_q[AW-1:0]),
		.wdata ({sgn_q, end_q, start_q}),
		.re    (rd_en),
		.raddr (scan_cnt_q[AW-1:0]),
		.rdata (rd_entry)
	);

	assign mctl.clr = accept;
	assign mctl.vld = vld_s1;

	sro_match u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mctl),
		.entry     (rd_entry),
		.range_lo  (start_q),
		.range_hi  (end_q),
		.boot_psw  (lpsw_q),
		.attr_psw  (apsw_q),
		.hits      (hits)
	);

	// Output register.
	assign count_ext = {7'd0, total_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {5'd0, count_ext[COUNT_W-1:0], res_mism, res_inval,
			              res_full, res_ovl};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The stored count never passes the table depth.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_RANGES))
		else $error("stored count above table depth");

	// A table write only lands below the depth.
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !is_full)
		else $error("table write while full");

	// Reads only address stored entries.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (scan_cnt_q < total_q))
		else $error("read beyond stored entries");

	// A taken item blocks the input until its result is posted.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("input taken while an item is in work");

	// A result is posted only when the output register can take it.
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!m_tvalid_q || m_tready))
		else $error("result overwrote a waiting item");

endmodule
